/* rtl/lbc_pkg.sv */
`timescale 1ns / 1ps

package lbc_pkg;

  // Default number of buffer slots.
  localparam int NUM_SLOTS_DEF = 32;

  // Field widths of the request and result transactions.
  localparam int DEV_W    = 8;
  localparam int BLOCK_W  = 32;
  localparam int SLOT_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_IODONE  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BUSY    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOBUF   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTHELD = 2'd3;

endpackage

/* rtl/lbc_slot_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port slot memory: one write port, one read port, registered read data.
module lbc_slot_ram #(
  parameter int DEPTH = lbc_pkg::NUM_SLOTS_DEF,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lru_block_buffer_cache.sv */
`timescale 1ns / 1ps
// Throughput: one request at a time; the next is taken the cycle after a result is
// registered. The single slot memory read port sets this: each scan reads one slot a cycle.
// Reset: synchronous, active high; afterwards a clearing pass over all slots
// initializes the slot memory while s_tready stays low.
module lru_block_buffer_cache #(
  parameter int NUM_SLOTS = lbc_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // dev [7:0], blockno [39:8], slot [44:40], zero fill
  input  logic [1:0]  s_tuser,  // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // slot_out [4:0], status [6:5], need_read [7],
                                // need_write [8], zero fill
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [lbc_pkg::DEV_W-1:0]   dev;
    logic [lbc_pkg::BLOCK_W-1:0] blk;
    logic                        occ;
    logic                        busy;
    logic                        dirty;
    logic                        valid;
    logic [AW-1:0]               rank;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_GSCAN, S_GDEC, S_MODIFY, S_RSCAN, S_DONE
  } state_t;

  state_t state;
  logic [AW-1:0] idx;

  logic [lbc_pkg::FUNC_W-1:0]  func_r;
  logic [lbc_pkg::DEV_W-1:0]   dev_r;
  logic [lbc_pkg::BLOCK_W-1:0] blk_r;
  logic [AW-1:0]               slot_idx_r;

  logic          hit_found;
  logic [AW-1:0] hit_idx;
  entry_t        hit_entry;
  logic          vic_found;
  logic [AW-1:0] vic_idx;
  entry_t        vic_entry;
  logic [AW-1:0] rel_rank;

  logic [lbc_pkg::SLOT_W-1:0]   res_slot;
  logic [lbc_pkg::STATUS_W-1:0] res_status;
  logic                         res_read;
  logic                         res_write;

  logic          ram_wen;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        wr_entry;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_entry;

  logic [lbc_pkg::FUNC_W-1:0]  in_func;
  logic [lbc_pkg::DEV_W-1:0]   in_dev;
  logic [lbc_pkg::BLOCK_W-1:0] in_blk;
  logic [lbc_pkg::SLOT_W-1:0]  in_slot;
  logic                        in_slot_ok;
  logic                        rd_match;
  logic                        rd_cand;
  logic                        out_free;

  assign in_func    = s_tuser;
  assign in_dev     = s_tdata[7:0];
  assign in_blk     = s_tdata[39:8];
  assign in_slot    = s_tdata[44:40];
  assign in_slot_ok = 32'(in_slot) < 32'(NUM_SLOTS);

  assign rd_entry = entry_t'(ram_rdata);
  assign rd_match = rd_entry.occ && (rd_entry.dev == dev_r) && (rd_entry.blk == blk_r);
  assign rd_cand  = !rd_entry.busy && !rd_entry.dirty;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  lbc_slot_ram #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(EW)
  ) u_ram (
    .clk  (clk),
    .wen  (ram_wen),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Memory address and write data for the current step.
  always_comb begin
    ram_wen   = 1'b0;
    ram_waddr = idx;
    ram_raddr = idx + AW'(1);
    wr_entry  = rd_entry;
    case (state)
      S_CLEAR: begin
        ram_wen       = 1'b1;
        wr_entry      = '0;
        wr_entry.rank = LAST - idx;
      end
      S_IDLE: begin
        ram_raddr = (in_func == lbc_pkg::FUNC_GET) ? '0 : AW'(in_slot);
      end
      S_GSCAN: begin
        ram_raddr = idx + AW'(1);
      end
      S_GDEC: begin
        if (hit_found) begin
          ram_waddr     = hit_idx;
          wr_entry      = hit_entry;
          wr_entry.busy = 1'b1;
          ram_wen       = !hit_entry.busy;
        end else begin
          ram_waddr      = vic_idx;
          wr_entry       = vic_entry;
          wr_entry.dev   = dev_r;
          wr_entry.blk   = blk_r;
          wr_entry.occ   = 1'b1;
          wr_entry.busy  = 1'b1;
          wr_entry.dirty = 1'b0;
          wr_entry.valid = 1'b0;
          ram_wen        = vic_found;
        end
      end
      S_MODIFY: begin
        ram_raddr = '0;
        ram_waddr = slot_idx_r;
        if (func_r == lbc_pkg::FUNC_WRITE) begin
          wr_entry.dirty = 1'b1;
          ram_wen        = rd_entry.busy;
        end else if (func_r == lbc_pkg::FUNC_IODONE) begin
          wr_entry.valid = 1'b1;
          wr_entry.dirty = 1'b0;
          ram_wen        = 1'b1;
        end
      end
      S_RSCAN: begin
        ram_wen = 1'b1;
        if (idx == slot_idx_r) begin
          wr_entry.rank = '0;
          wr_entry.busy = 1'b0;
        end else if (rd_entry.rank < rel_rank) begin
          wr_entry.rank = rd_entry.rank + AW'(1);
        end
      end
      default: begin
        ram_wen = 1'b0;
      end
    endcase
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      m_tvalid  <= 1'b0;
      hit_found <= 1'b0;
      vic_found <= 1'b0;
    end else begin
      // A taken result drops valid unless the next one is loaded in the same cycle.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            func_r     <= in_func;
            dev_r      <= in_dev;
            blk_r      <= in_blk;
            slot_idx_r <= AW'(in_slot);
            hit_found  <= 1'b0;
            vic_found  <= 1'b0;
            idx        <= '0;
            res_slot   <= in_slot;
            res_read   <= 1'b0;
            res_write  <= 1'b0;
            if (in_func == lbc_pkg::FUNC_GET) begin
              state <= S_GSCAN;
            end else if (!in_slot_ok) begin
              res_status <= lbc_pkg::STAT_NOTHELD;
              state      <= S_DONE;
            end else begin
              state <= S_MODIFY;
            end
          end
        end
        S_GSCAN: begin
          // First matching slot, and the least recent clean free slot.
          if (rd_match && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
            hit_entry <= rd_entry;
          end
          if (rd_cand && (!vic_found || rd_entry.rank > vic_entry.rank)) begin
            vic_found <= 1'b1;
            vic_idx   <= idx;
            vic_entry <= rd_entry;
          end
          idx <= idx + AW'(1);
          if (idx == LAST) begin
            state <= S_GDEC;
          end
        end
        S_GDEC: begin
          state <= S_DONE;
          if (hit_found) begin
            res_slot <= 5'(hit_idx);
            if (hit_entry.busy) begin
              res_status <= lbc_pkg::STAT_BUSY;
            end else begin
              res_status <= lbc_pkg::STAT_OK;
              res_read   <= !hit_entry.valid;
            end
          end else if (vic_found) begin
            res_slot   <= 5'(vic_idx);
            res_status <= lbc_pkg::STAT_OK;
            res_read   <= 1'b1;
          end else begin
            res_status <= lbc_pkg::STAT_NOBUF;
          end
        end
        S_MODIFY: begin
          state <= S_DONE;
          if (func_r == lbc_pkg::FUNC_IODONE) begin
            res_status <= lbc_pkg::STAT_OK;
          end else if (!rd_entry.busy) begin
            res_status <= lbc_pkg::STAT_NOTHELD;
          end else if (func_r == lbc_pkg::FUNC_WRITE) begin
            res_status <= lbc_pkg::STAT_OK;
            res_write  <= 1'b1;
          end else begin
            // Release of a held slot: rank update pass over all slots.
            res_status <= lbc_pkg::STAT_OK;
            rel_rank   <= rd_entry.rank;
            idx        <= '0;
            state      <= S_RSCAN;
          end
        end
        S_RSCAN: begin
          idx <= idx + AW'(1);
          if (idx == LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, res_write, res_read, res_status, res_slot};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lbc_checker.sv */
`timescale 1ns / 1ps

// Port-level checks for the buffer cache.
module lbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

  // A disk write request only comes with an ok status.
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[6:5] == lbc_pkg::STAT_OK)
    else $error("need_write with a failing status");

  // A result never asks for both a read and a write.
  a_read_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[7] && m_tdata[8]))
    else $error("need_read and need_write both set");

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int NSLOT      = lbc_pkg::NUM_SLOTS_DEF;
  localparam int CYCLE_CAP  = 500000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 2 * NSLOT + 10;

  // One request and one reply, field by field.
  typedef struct {
    logic [lbc_pkg::FUNC_W-1:0]  func;
    logic [lbc_pkg::DEV_W-1:0]   dev;
    logic [lbc_pkg::BLOCK_W-1:0] blockno;
    logic [lbc_pkg::SLOT_W-1:0]  slot;
  } cache_req_t;

  typedef struct {
    logic [lbc_pkg::SLOT_W-1:0]   slot_out;
    logic [lbc_pkg::STATUS_W-1:0] status;
    logic                         need_read;
    logic                         need_write;
  } cache_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // dev [7:0], blockno [39:8], slot [44:40], zero fill
  logic [1:0]  s_tuser = '0;  // func [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // slot_out [4:0], status [6:5], need_read [7],
                              // need_write [8], zero fill

  lru_block_buffer_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the slot table used to predict every reply.
  logic [lbc_pkg::DEV_W-1:0]   shadow_dev [NSLOT];
  logic [lbc_pkg::BLOCK_W-1:0] shadow_blk [NSLOT];
  logic [NSLOT-1:0]            occupied_v;
  logic [NSLOT-1:0]            busy_v;
  logic [NSLOT-1:0]            dirty_v;
  logic [NSLOT-1:0]            valid_v;
  int                          age_rank [NSLOT];

  cache_reply_t expected_replies [$];

  int   error_count = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  event hold_off_trig;

  // Tag pools: few devices and blocks, so that tags share one field and hits are common.
  logic [lbc_pkg::DEV_W-1:0]   dev_pool [4];
  logic [lbc_pkg::BLOCK_W-1:0] blk_pool [12];
  logic [lbc_pkg::BLOCK_W-1:0] fresh_blk = 32'h8000_0000;

  function automatic void clear_shadow();
    for (int i = 0; i < NSLOT; i++) begin
      shadow_dev[i] = '0;
      shadow_blk[i] = '0;
      age_rank[i]   = NSLOT - 1 - i;
    end
    occupied_v = '0;
    busy_v     = '0;
    dirty_v    = '0;
    valid_v    = '0;
  endfunction

  // Apply one request to the shadow table and return the reply the cache must give.
  function automatic cache_reply_t predict_reply(cache_req_t q);
    cache_reply_t r;
    logic         hit_found;
    int           hit;
    int           best;
    int           old_rank;
    r.slot_out   = q.slot;
    r.status     = lbc_pkg::STAT_OK;
    r.need_read  = 1'b0;
    r.need_write = 1'b0;
    hit_found    = 1'b0;
    hit          = 0;
    if (q.func == lbc_pkg::FUNC_GET) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!hit_found && occupied_v[i] && shadow_dev[i] == q.dev
            && shadow_blk[i] == q.blockno) begin
          hit_found = 1'b1;
          hit       = i;
        end
      end
      if (hit_found) begin
        r.slot_out = hit[lbc_pkg::SLOT_W-1:0];
        if (busy_v[hit]) begin
          r.status = lbc_pkg::STAT_BUSY;
        end else begin
          busy_v[hit] = 1'b1;
          r.need_read = !valid_v[hit];
        end
        return r;
      end
      // Miss: evict the least recent slot that is neither held nor dirty.
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!busy_v[i] && !dirty_v[i] && age_rank[i] > best) begin
          best = age_rank[i];
          hit  = i;
        end
      end
      if (best < 0) begin
        r.status = lbc_pkg::STAT_NOBUF;
        return r;
      end
      shadow_dev[hit] = q.dev;
      shadow_blk[hit] = q.blockno;
      occupied_v[hit] = 1'b1;
      busy_v[hit]     = 1'b1;
      dirty_v[hit]    = 1'b0;
      valid_v[hit]    = 1'b0;
      r.slot_out      = hit[lbc_pkg::SLOT_W-1:0];
      r.need_read     = 1'b1;
      return r;
    end
    if (int'(q.slot) >= NSLOT) begin
      r.status = lbc_pkg::STAT_NOTHELD;
      return r;
    end
    case (q.func)
      lbc_pkg::FUNC_WRITE: begin
        if (!busy_v[q.slot]) begin
          r.status = lbc_pkg::STAT_NOTHELD;
        end else begin
          dirty_v[q.slot] = 1'b1;
          r.need_write    = 1'b1;
        end
      end
      lbc_pkg::FUNC_RELEASE: begin
        if (!busy_v[q.slot]) begin
          r.status = lbc_pkg::STAT_NOTHELD;
        end else begin
          old_rank = age_rank[q.slot];
          for (int i = 0; i < NSLOT; i++) begin
            if (age_rank[i] < old_rank) age_rank[i]++;
          end
          age_rank[q.slot] = 0;
          busy_v[q.slot]   = 1'b0;
        end
      end
      default: begin
        valid_v[q.slot] = 1'b1;
        dirty_v[q.slot] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Random slot, taken from the marked ones when any are marked.
  function automatic logic [lbc_pkg::SLOT_W-1:0] pick_slot(logic [NSLOT-1:0] mask);
    int s;
    if (mask == '0) return lbc_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
    do s = $urandom_range(0, NSLOT - 1); while (!mask[s]);
    return lbc_pkg::SLOT_W'(s);
  endfunction

  // Offer one request with random idle gaps and record its reply once accepted.
  task automatic send_req(logic [lbc_pkg::FUNC_W-1:0] func, logic [lbc_pkg::DEV_W-1:0] dev,
                          logic [lbc_pkg::BLOCK_W-1:0] blk,
                          logic [lbc_pkg::SLOT_W-1:0] slot);
    cache_req_t q;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, slot, blk, dev};
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    q.func    = func;
    q.dev     = dev;
    q.blockno = blk;
    q.slot    = slot;
    expected_replies.push_back(predict_reply(q));
  endtask

  // Drop valid in the step of the last transaction and wait for every reply.
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed get, write, I/O done and release traffic, with some noise.
  task automatic send_random_item();
    int                          roll;
    logic [lbc_pkg::DEV_W-1:0]   dev;
    logic [lbc_pkg::BLOCK_W-1:0] blk;
    roll = $urandom_range(0, 99);
    if (roll < 34 && $countones(busy_v) > 20) roll = 60;
    dev = dev_pool[$urandom_range(0, 3)];
    blk = blk_pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 9) == 0) begin
      dev = lbc_pkg::DEV_W'($urandom_range(0, 255));
      blk = $urandom();
    end
    if (roll < 34)
      send_req(lbc_pkg::FUNC_GET, dev, blk, lbc_pkg::SLOT_W'($urandom_range(0, NSLOT - 1)));
    else if (roll < 56)
      send_req(lbc_pkg::FUNC_WRITE, dev, blk,
               pick_slot($urandom_range(0, 4) != 0 ? busy_v : '0));
    else if (roll < 80)
      send_req(lbc_pkg::FUNC_RELEASE, dev, blk,
               pick_slot($urandom_range(0, 4) != 0 ? busy_v : '0));
    else if (roll < 92)
      send_req(lbc_pkg::FUNC_IODONE, dev, blk,
               pick_slot($urandom_range(0, 2) != 0 ? dirty_v : '0));
    else
      send_req(lbc_pkg::FUNC_W'($urandom_range(0, 3)), dev, blk,
               lbc_pkg::SLOT_W'($urandom_range(0, 31)));
  endtask

  // Every operation, and the ok, busy and not-held statuses, at the field extremes.
  task automatic test_basic_ops();
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    send_req(lbc_pkg::FUNC_GET,     8'h00, 32'h0000_0000, 5'd31);
    send_req(lbc_pkg::FUNC_GET,     8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_WRITE,   8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_WRITE,   8'h00, 32'h0000_0000, 5'd5);
    send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd7);
    send_req(lbc_pkg::FUNC_IODONE,  8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_GET,     8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_GET,     8'hFF, 32'hFFFF_FFFF, 5'd31);
    send_req(lbc_pkg::FUNC_GET,     8'hFF, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_GET,     8'h00, 32'hFFFF_FFFF, 5'd0);
    send_req(lbc_pkg::FUNC_WRITE,   8'hFF, 32'hFFFF_FFFF, 5'd1);
    send_req(lbc_pkg::FUNC_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1);
    // A hit on a free but dirty slot still asks for a read when not yet valid.
    send_req(lbc_pkg::FUNC_GET,     8'hFF, 32'hFFFF_FFFF, 5'd0);
    send_req(lbc_pkg::FUNC_IODONE,  8'h00, 32'h0000_0000, 5'd31);
    send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd31);
    for (int i = 0; i < 4; i++)
      send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, lbc_pkg::SLOT_W'(i));
    send_req(lbc_pkg::FUNC_GET,     8'h00, 32'h0000_0000, 5'd0);
    send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0000_0000, 5'd0);
    finish_phase();
  endtask

  // Claim every clean free slot, then hit the no-buffer and busy cases, then empty out.
  task automatic test_cache_full();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    while ((~busy_v & ~dirty_v) != '0) begin
      send_req(lbc_pkg::FUNC_GET, 8'hC3, fresh_blk, 5'd0);
      fresh_blk++;
    end
    send_req(lbc_pkg::FUNC_GET, 8'hC3, fresh_blk, 5'd17);
    send_req(lbc_pkg::FUNC_GET, 8'hC3, 32'h8000_0000, 5'd0);
    for (int i = 0; i < NSLOT; i++) begin
      if (busy_v[i]) send_req(lbc_pkg::FUNC_RELEASE, 8'h00, 32'h0, lbc_pkg::SLOT_W'(i));
      if (dirty_v[i]) send_req(lbc_pkg::FUNC_IODONE, 8'h00, 32'h0, lbc_pkg::SLOT_W'(i));
    end
    finish_phase();
  endtask

  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) send_random_item();
    finish_phase();
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> hold_off_trig;
    for (int n = 0; n < 30; n++) send_random_item();
    finish_phase();
  endtask

  // Receiver ready, with random idling and the long hold-off.
  always @(posedge clk) begin
    m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    int held;
    forever begin
      @(hold_off_trig);
      @(posedge clk);
      rx_hold <= 1'b1;
      for (held = 0; held < HOLD_LEN; held++) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Compare each reply transaction with the oldest prediction.
  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (m_tdata[4:0] !== want.slot_out) begin
          $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out,
                   m_tdata[4:0]);
          error_count++;
        end
        if (m_tdata[6:5] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[6:5]);
          error_count++;
        end
        if (m_tdata[7] !== want.need_read) begin
          $display("%0t: need_read expected %0b actual %0b", $time, want.need_read,
                   m_tdata[7]);
          error_count++;
        end
        if (m_tdata[8] !== want.need_write) begin
          $display("%0t: need_write expected %0b actual %0b", $time, want.need_write,
                   m_tdata[8]);
          error_count++;
        end
      end
    end
  end

  // Cycle counter that stops a hung run.
  initial begin
    int cyc;
    for (cyc = 0; cyc < CYCLE_CAP; cyc++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Main sequence.
  initial begin
    clear_shadow();
    foreach (dev_pool[i]) dev_pool[i] = lbc_pkg::DEV_W'($urandom_range(0, 255));
    foreach (blk_pool[i]) blk_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_cache_full();
    test_random_traffic(210, 20, 87);
    test_random_traffic(210, 87, 20);
    test_random_traffic(210, 0, 0);
    test_output_stall();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/lbc_pkg.sv
rtl/lbc_slot_ram.sv
rtl/lru_block_buffer_cache.sv
rtl/lbc_checker.sv
tb/tb_top.sv
